// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/aes128_pkg.sv =====
// Shared types, constants and GF(2^8) functions for the AES-128 pipeline
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam logic [63:0] KeyHighReset = 64'h4141414141413131;
  localparam logic [63:0] KeyLowReset  = 64'h3131313171717171;

  // Configuration register indexes
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_word_t;

  typedef struct packed {
    logic [63:0] crypt_high;
    logic [63:0] crypt_low;
  } crypt_word_t;

  // Word handed from one round cell to the next
  typedef struct packed {
    logic         valid;
    logic [127:0] state;
    logic [127:0] rkey;
    logic [7:0]   rcon;
  } round_word_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // S-box lookup table
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Byte i of the state, byte 0 most significant
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int unsigned i);
    get_byte = v[127-8*i -: 8];
  endfunction

endpackage

// ===== hw/rtl/aes128_encrypt_block_top.sv =====
// Top level: key registers, initial AddRoundKey and the row of ten round cells
//
//  channel  direction  handshake          payload
//  cfg      in         cfg_we             cfg_index, cfg_data
//  in       in         start & !busy      plain (plain_word_t)
//  out      out        done strobe        crypt (crypt_word_t)
//
// One word accepted per cycle; its result strobes after the input
// register and one register per round cell.
// busy is never raised: the row of cells takes a word every cycle.
// rst synchronously clears every valid bit and reloads the reset key.
// The receiver cannot stall; done lasts exactly one cycle per word.
module aes128_encrypt_block_top
  import aes128_pkg::*;
#(
  parameter int unsigned Rounds = NumRounds
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  plain_word_t plain,
  output logic        done,
  output crypt_word_t crypt,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

`include "assert_macros.svh"

  logic [63:0] key_high;
  logic [63:0] key_low;
  round_word_t chain [Rounds+1];

  assign busy = 1'b0;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= KeyHighReset;
      key_low  <= KeyLowReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyHigh: key_high <= cfg_data;
        RegKeyLow:  key_low  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Input register with the initial AddRoundKey
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= start & ~busy;
    end
    chain[0].state <= {plain.plain_high, plain.plain_low} ^ {key_high, key_low};
    chain[0].rkey  <= {key_high, key_low};
    chain[0].rcon  <= 8'h01;
  end

  // Row of round cells
  for (genvar g = 0; g < Rounds; g++) begin : g_round
    aes128_round_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .last (g == Rounds - 1),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  assign done = chain[Rounds].valid;
  assign crypt.crypt_high = chain[Rounds].state[127:64];
  assign crypt.crypt_low  = chain[Rounds].state[63:0];

  `ASSERT_CLK(a_busy_low, clk, rst, !busy, "busy raised")
  `ASSERT_CLK(a_first_stage, clk, rst, chain[0].valid == $past(start), "stage 0 lost a word")
  `ASSERT_CLK(a_rcon_first, clk, rst, chain[0].valid |-> chain[0].rcon == 8'h01, "bad rcon")
  `ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> !chain[0].valid, "valid after reset")

endmodule

// ===== hw/rtl/aes128_round_cell.sv =====
// One round cell: SubBytes, ShiftRows, optional MixColumns, key step, AddRoundKey
module aes128_round_cell
  import aes128_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        last,
  input  round_word_t din,
  output round_word_t dout
);

  logic [127:0] sh;
  logic [127:0] mx;
  logic [127:0] nk;
  logic [127:0] st_next;

  // SubBytes with ShiftRows folded into the byte selection
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh[127-8*(4*c+r) -: 8] = SBOX[get_byte(din.state, 4*((c+r)%4)+r)];
      end
    end
  end

  // MixColumns
  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(sh, 4*c);
      a1 = get_byte(sh, 4*c+1);
      a2 = get_byte(sh, 4*c+2);
      a3 = get_byte(sh, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mx[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mx[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mx[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mx[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
  end

  // Next round key: RotWord, SubWord, Rcon, then the word chain
  always_comb begin
    logic [31:0] t;
    t = {SBOX[get_byte(din.rkey, 13)] ^ din.rcon, SBOX[get_byte(din.rkey, 14)],
         SBOX[get_byte(din.rkey, 15)], SBOX[get_byte(din.rkey, 12)]};
    nk[127:96] = din.rkey[127:96] ^ t;
    nk[95:64]  = din.rkey[95:64] ^ nk[127:96];
    nk[63:32]  = din.rkey[63:32] ^ nk[95:64];
    nk[31:0]   = din.rkey[31:0] ^ nk[63:32];
  end

  assign st_next = (last ? sh : mx) ^ nk;

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.state <= st_next;
    dout.rkey  <= nk;
    dout.rcon  <= xtime(din.rcon);
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the AES-128 block encryption pipeline, checked against a behavioral cipher
`timescale 1ns / 100ps

module tb_top
  import aes128_pkg::*;
;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  plain_word_t plain;
  logic        done;
  crypt_word_t crypt;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  aes128_encrypt_block_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .plain(plain),
    .done(done), .crypt(crypt), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Pipeline depth: the input register plus one register per round cell
  localparam int Latency = 11;

  logic [127:0] cipher_key;
  crypt_word_t  ciphertext_q[$];
  int           fail_count;
  int           send_idle_pct;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // GF(2^8) helpers for the predictor
  function automatic logic [7:0] dbl(input logic [7:0] a);
    dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    gmul = p;
  endfunction

  // S-box computed as inverse (x^254) then affine map
  function automatic logic [7:0] subst(input logic [7:0] x);
    logic [7:0] inv, base;
    int         e;
    inv = 8'h01;
    base = x;
    e = 254;
    while (e != 0) begin
      if (e & 1) inv = gmul(inv, base);
      base = gmul(base, base);
      e = e >> 1;
    end
    subst = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // Full AES-128 encryption of one block
  function automatic crypt_word_t encrypt_block(input plain_word_t pw, input logic [127:0] key);
    logic [7:0]  st[16], t[16], k[16];
    logic [7:0]  rc, a0, a1, a2, a3, all;
    logic [127:0] blk, res;
    crypt_word_t cw;
    blk = {pw.plain_high, pw.plain_low};
    for (int i = 0; i < 16; i++) begin
      st[i] = blk[127-8*i -: 8];
      k[i] = key[127-8*i -: 8];
    end
    rc = 8'h01;
    for (int i = 0; i < 16; i++) st[i] ^= k[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[4*c+w] = subst(st[4*((c+w)&3)+w]);
      st = t;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
        end
      end
      // next round key
      k[0] ^= subst(k[13]) ^ rc;
      k[1] ^= subst(k[14]);
      k[2] ^= subst(k[15]);
      k[3] ^= subst(k[12]);
      for (int i = 4; i < 16; i++) k[i] ^= k[i-4];
      rc = dbl(rc);
      for (int i = 0; i < 16; i++) st[i] ^= k[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    cw.crypt_high = res[127:64];
    cw.crypt_low = res[63:0];
    encrypt_block = cw;
  endfunction

  // Send one word; predict at acceptance. start stays high afterwards
  // until the next idle cycle or a drain lowers it.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    plain <= '{plain_high: hi, plain_low: lo};
    @(posedge clk);
    while (busy) @(posedge clk);
    ciphertext_q.push_back(encrypt_block('{plain_high: hi, plain_low: lo}, cipher_key));
    @(negedge clk);
  endtask

  // Wait for the pipe to drain, then for its depth
  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (ciphertext_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (Latency + 2) @(negedge clk);
  endtask

  // Write both key halves on consecutive cycles
  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    cfg_we <= 1'b1;
    cfg_index <= RegKeyHigh;
    cfg_data <= hi;
    @(negedge clk);
    cfg_index <= RegKeyLow;
    cfg_data <= lo;
    @(negedge clk);
    cfg_we <= 1'b0;
    cipher_key = {hi, lo};
  endtask

  // Result checker
  always @(posedge clk) begin
    crypt_word_t exp_w;
    if (!rst && done) begin
      if (ciphertext_q.size() == 0) begin
        $error("unexpected result crypt_high=%h crypt_low=%h", crypt.crypt_high,
               crypt.crypt_low);
        fail_count++;
      end else begin
        exp_w = ciphertext_q.pop_front();
        if (crypt.crypt_high !== exp_w.crypt_high) begin
          $error("crypt_high expected %h actual %h", exp_w.crypt_high, crypt.crypt_high);
          fail_count++;
        end
        if (crypt.crypt_low !== exp_w.crypt_low) begin
          $error("crypt_low expected %h actual %h", exp_w.crypt_low, crypt.crypt_low);
          fail_count++;
        end
      end
    end
  end

  // Reset key, field extremes, single and alternating bits, a known vector, then zero and all-ones keys
  task automatic test_directed();
    send_block('0, '0);
    send_block('1, '1);
    send_block('1, '0);
    send_block('0, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    // FIPS-197 appendix vector key
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('0, '1);
    drain();
    write_key('0, '0);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    write_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    drain();
  endtask

  // Random blocks under a random key
  task automatic test_random(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    for (int i = 0; i < count; i++) begin
      send_block({$urandom, $urandom}, {$urandom, $urandom});
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    plain = '0;
    cfg_we = 1'b0;
    cfg_index = RegKeyHigh;
    cfg_data = '0;
    fail_count = 0;
    send_idle_pct = 0;
    cipher_key = {KeyHighReset, KeyLowReset};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(610, 34);
    test_random(610, 75);
    test_random(610, 0);
    if (fail_count == 0 && ciphertext_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/aes128_pkg.sv
hw/rtl/aes128_round_cell.sv
hw/rtl/aes128_encrypt_block_top.sv
tb/tb_top.sv
